@@ rtl/spd_pkg.sv @@
`default_nettype none

package spd_pkg;

	localparam logic [7:0] HDR_FIRST      = 8'h10;
	localparam logic [7:0] HDR_SECOND     = 8'h01;
	localparam logic [7:0] MAX_LEN_RESET  = 8'd64;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] pbyte;
		logic [7:0] position;
		logic [7:0] ftype;
		logic [7:0] length;
		logic       good;
	} spd_result_t;

endpackage

`default_nettype wire

@@ rtl/spd_core.sv @@
`default_nettype none

module spd_core
	import spd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  max_len,
	output logic             res_valid,
	output spd_result_t      res
);

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_TYPE,
		PH_LEN,
		PH_PAYLOAD,
		PH_CKLO,
		PH_CKHI
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] type_q, type_d;
	logic [7:0] len_q, len_d;
	logic [7:0] count_q, count_d;
	logic [7:0] sum_lo_q, sum_lo_d;
	logic [7:0] sum_hi_q, sum_hi_d;
	logic [7:0] ck_lo_q, ck_lo_d;

	logic [7:0] acc_lo;
	logic [7:0] acc_hi;
	logic [7:0] count_inc;

	// fletcher step with the current byte
	assign acc_lo    = sum_lo_q + rx_byte;
	assign acc_hi    = sum_hi_q + acc_lo;
	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_lo_d  = sum_lo_q;
		sum_hi_d  = sum_hi_q;
		ck_lo_d   = ck_lo_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_PAYLOAD, pbyte: 8'd0, position: count_q,
			ftype: type_q, length: len_q, good: 1'b0};
		unique case (phase_q)
			PH_HUNT0, PH_HUNT1: begin
				if (phase_q == PH_HUNT1 && rx_byte == HDR_SECOND) begin
					sum_lo_d = acc_lo;
					sum_hi_d = acc_hi;
					phase_d  = PH_TYPE;
				end else if (rx_byte == HDR_FIRST) begin
					// fresh frame: sums already hold the first header byte
					type_d   = 8'd0;
					len_d    = 8'd0;
					count_d  = 8'd0;
					ck_lo_d  = 8'd0;
					sum_lo_d = HDR_FIRST;
					sum_hi_d = HDR_FIRST;
					phase_d  = PH_HUNT1;
				end else begin
					phase_d = PH_HUNT0;
				end
			end
			PH_TYPE: begin
				type_d   = rx_byte;
				sum_lo_d = acc_lo;
				sum_hi_d = acc_hi;
				phase_d  = PH_LEN;
			end
			PH_LEN: begin
				if (rx_byte > max_len) begin
					phase_d = PH_HUNT0;
				end else begin
					len_d    = rx_byte;
					sum_lo_d = acc_lo;
					sum_hi_d = acc_hi;
					count_d  = 8'd0;
					phase_d  = (rx_byte == 8'd0) ? PH_CKLO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_lo_d  = acc_lo;
				sum_hi_d  = acc_hi;
				res_valid = 1'b1;
				res.pbyte = rx_byte;
				count_d   = count_inc;
				if (count_inc == len_q) begin
					phase_d = PH_CKLO;
				end
			end
			PH_CKLO: begin
				ck_lo_d = rx_byte;
				phase_d = PH_CKHI;
			end
			PH_CKHI: begin
				res_valid = 1'b1;
				res.kind  = KIND_VERDICT;
				res.good  = (ck_lo_q == sum_lo_q) && (rx_byte == sum_hi_q);
				phase_d   = PH_HUNT0;
			end
			default: begin
				phase_d = PH_HUNT0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT0;
			type_q   <= 8'd0;
			len_q    <= 8'd0;
			count_q  <= 8'd0;
			sum_lo_q <= 8'd0;
			sum_hi_q <= 8'd0;
			ck_lo_q  <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_q    <= len_d;
			count_q  <= count_d;
			sum_lo_q <= sum_lo_d;
			sum_hi_q <= sum_hi_d;
			ck_lo_q  <= ck_lo_d;
		end
	end

`ifndef SYNTHESIS
	// payload items always sit inside the declared length
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == KIND_PAYLOAD |-> res.position < res.length)
		else $error("payload position beyond frame length");

	// a verdict counts exactly the declared payload
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == KIND_VERDICT |-> res.position == res.length)
		else $error("verdict count differs from frame length");

	// an accepted length never exceeds the configured maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && phase_d != PH_HUNT0 |-> rx_byte <= max_len)
		else $error("oversize length accepted");
`endif

endmodule

`default_nettype wire

@@ rtl/serial_packet_deframer.sv @@
// serial packet deframer
// s_tdata carries one received byte per item. the block hunts for the header
// 0x10 0x01, then takes type, length, payload and a two-byte checksum (low
// byte first), with fletcher sums mod 256 over header, type, length and
// payload. each payload byte leaves as an item with m_tuser = 0; the high
// checksum byte yields an item with m_tuser = 1 and the good flag.
// frames longer than the configured maximum are dropped silently.
// cfg_we / cfg_wdata set the maximum payload length (reset 64); write only
// while the block is idle.
// a result reaches m_tvalid after its byte passes the input register, then the
// result register. one byte per cycle is sustained while results are taken:
// the frame logic is a single pass between the two registers.
// when m_tready is low with a result held, the byte in the input register
// waits and s_tready drops once that register is full.
// reset: hunting the first header byte, sums and counters cleared, maximum 64,
// both registers empty.
`default_nettype none

module serial_packet_deframer
	import spd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_position,
	                                    // [23:16] frame_type, [31:24] frame_length,
	                                    // [32] frame_good, [39:33] zero
	output logic             m_tuser,   // [0] result_kind
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  max_len_q;
	logic        out_valid_q;
	spd_result_t out_q;

	logic        advance;
	logic        step;
	logic        res_valid;
	spd_result_t res;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	spd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {7'd0, out_q.good, out_q.length, out_q.ftype,
		out_q.position, out_q.pbyte};

`ifndef SYNTHESIS
	// input side only stalls behind a held, untaken result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a held result");

	// payload items never carry a good flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[32] == 1'b0)
		else $error("good flag on a payload item");

	// verdict items carry a zero payload byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_VERDICT |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero byte on a verdict item");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
module testbench;
	import spd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned LONG_HOLD   = 300;

	typedef enum logic [2:0] {
		HUNT_SYNC,
		HUNT_SECOND,
		GET_TYPE,
		GET_LENGTH,
		GET_PAYLOAD,
		GET_CHECK_LO,
		GET_CHECK_HI
	} rx_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;           // [7:0] payload_byte, [15:8] payload_position,
	                                // [23:16] frame_type, [31:24] frame_length,
	                                // [32] frame_good, [39:33] zero
	logic        m_tuser;           // [0] result_kind
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;

	serial_packet_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// byte stream waiting for the driver, and the deframed items still due
	logic [7:0]   rx_bytes_pending[$];
	spd_result_t  deframed_due[$];

	int unsigned bytes_queued = 0;
	int unsigned bytes_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned payload_seen = 0;
	int unsigned frames_good = 0;
	int unsigned frames_bad = 0;
	int unsigned frames_dropped = 0;

	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;
	int unsigned stall_req = 0;
	int unsigned stall_ack = 0;
	logic [7:0]  mid_limit;

	// deframer state as the block should hold it
	rx_phase_t   ph = HUNT_SYNC;
	logic [7:0]  cur_type = 8'h00;
	logic [7:0]  cur_len = 8'h00;
	logic [7:0]  pay_cnt = 8'h00;
	logic [7:0]  sum1 = 8'h00;
	logic [7:0]  sum2 = 8'h00;
	logic [7:0]  ck_lo = 8'h00;
	logic [7:0]  max_len_model = MAX_LEN_RESET;

	function automatic void fold(input logic [7:0] b);
		sum1 = sum1 + b;
		sum2 = sum2 + sum1;
	endfunction

	function automatic void open_frame();
		cur_type = 8'h00;
		cur_len = 8'h00;
		pay_cnt = 8'h00;
		sum1 = 8'h00;
		sum2 = 8'h00;
		ck_lo = 8'h00;
		fold(HDR_FIRST);
		ph = HUNT_SECOND;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		spd_result_t r;
		case (ph)
			HUNT_SYNC: begin
				if (b == HDR_FIRST)
					open_frame();
			end
			HUNT_SECOND: begin
				if (b == HDR_SECOND) begin
					fold(b);
					ph = GET_TYPE;
				end else if (b == HDR_FIRST) begin
					open_frame();
				end else begin
					ph = HUNT_SYNC;
				end
			end
			GET_TYPE: begin
				cur_type = b;
				fold(b);
				ph = GET_LENGTH;
			end
			GET_LENGTH: begin
				if (b > max_len_model) begin
					frames_dropped++;
					ph = HUNT_SYNC;
				end else begin
					cur_len = b;
					fold(b);
					pay_cnt = 8'h00;
					ph = (b == 8'h00) ? GET_CHECK_LO : GET_PAYLOAD;
				end
			end
			GET_PAYLOAD: begin
				fold(b);
				r = '{kind: KIND_PAYLOAD, pbyte: b, position: pay_cnt, ftype: cur_type,
					length: cur_len, good: 1'b0};
				deframed_due.push_back(r);
				payload_seen++;
				pay_cnt = pay_cnt + 8'd1;
				if (pay_cnt == cur_len)
					ph = GET_CHECK_LO;
			end
			GET_CHECK_LO: begin
				ck_lo = b;
				ph = GET_CHECK_HI;
			end
			GET_CHECK_HI: begin
				r = '{kind: KIND_VERDICT, pbyte: 8'h00, position: pay_cnt, ftype: cur_type,
					length: cur_len, good: (ck_lo == sum1 && b == sum2)};
				deframed_due.push_back(r);
				if (r.good)
					frames_good++;
				else
					frames_bad++;
				ph = HUNT_SYNC;
			end
			default: ph = HUNT_SYNC;
		endcase
	endfunction

	// mostly back to back, often a short gap, now and then a long gap
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int unsigned pick_length(input logic [7:0] lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, (lim < 8'd8) ? lim : 8);
		if (r < 85)
			return $urandom_range(0, (lim < 8'd40) ? lim : 40);
		if (r < 90 || lim == 8'hFF)
			return $urandom_range(0, lim);
		return $urandom_range(lim + 1, 255);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		rx_bytes_pending.push_back(b);
		bytes_queued++;
	endtask

	// damage bit 0 spoils the low check byte, bit 1 the high one;
	// cut > 0 queues at most that many bytes of the frame
	task automatic queue_frame(input logic [7:0] ftype, input int unsigned flen,
			input int unsigned damage, input int unsigned cut, input bit corner_bytes);
		logic [7:0]  fb[$];
		logic [7:0]  lo, hi, pb;
		int unsigned i, r, n;
		fb.push_back(HDR_FIRST);
		fb.push_back(HDR_SECOND);
		fb.push_back(ftype);
		fb.push_back(8'(flen));
		for (i = 0; i < flen; i++) begin
			r = $urandom_range(0, 9);
			if (corner_bytes)
				pb = i[0] ? 8'hFF : 8'h00;
			else if (r == 0)
				pb = 8'h00;
			else if (r == 1)
				pb = 8'hFF;
			else if (r == 2)
				pb = HDR_FIRST;
			else
				pb = 8'($urandom_range(0, 255));
			fb.push_back(pb);
		end
		lo = 8'h00;
		hi = 8'h00;
		foreach (fb[k]) begin
			lo = lo + fb[k];
			hi = hi + lo;
		end
		if (damage[0])
			lo = lo ^ 8'($urandom_range(1, 255));
		if (damage[1])
			hi = hi ^ 8'($urandom_range(1, 255));
		fb.push_back(lo);
		fb.push_back(hi);
		n = (cut == 0 || cut > fb.size()) ? fb.size() : cut;
		for (i = 0; i < n; i++)
			send_byte(fb[i]);
	endtask

	task automatic queue_random_traffic(input int unsigned n);
		int unsigned stop_at, r, flen, cut, damage;
		stop_at = bytes_queued + n;
		while (bytes_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (r < 14) begin
				// header that goes wrong at the second byte
				send_byte(HDR_FIRST);
				send_byte($urandom_range(0, 1) ? HDR_FIRST : 8'($urandom_range(0, 255)));
			end else begin
				flen = pick_length(max_len_model);
				cut = 0;
				if (flen > max_len_model)
					cut = 4;
				else if ($urandom_range(0, 9) == 0)
					cut = $urandom_range(1, flen + 5);
				damage = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
				queue_frame(8'($urandom_range(0, 255)), flen, damage, cut, 1'b0);
			end
		end
	endtask

	// sender waits until every byte is taken and every item is out, then waits on for dropped bytes in flight
	task automatic wait_idle();
		while (bytes_taken != bytes_queued || deframed_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		max_len_model = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic note_mismatch(input string what, input spd_result_t want,
			input spd_result_t got, input logic [6:0] pad);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): expected kind %0d byte %02h pos %0d type %02h len %0d good %0d",
				what, want.kind, want.pbyte, want.position, want.ftype, want.length,
				want.good);
			$display("  got kind %0d byte %02h pos %0d type %02h len %0d good %0d pad %02h",
				got.kind, got.pbyte, got.position, got.ftype, got.length, got.good, pad);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still due", cycles,
				deframed_due.size());
			$display("FAIL serial_packet_deframer");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (rx_bytes_pending.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= rx_bytes_pending.pop_front();
					if (tx_idle)
						tx_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness, with a long hold-off on request
	always @(posedge clk) begin
		if (stall_ack != stall_req) begin
			stall_ack = stall_req;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle)
				rx_gap = pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		spd_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind: m_tuser, pbyte: m_tdata[7:0], position: m_tdata[15:8],
				ftype: m_tdata[23:16], length: m_tdata[31:24], good: m_tdata[32]};
			if (deframed_due.size() == 0) begin
				want = '0;
				note_mismatch("unexpected item", want, got, m_tdata[39:33]);
			end else begin
				want = deframed_due.pop_front();
				if (got !== want || m_tdata[39:33] !== 7'd0)
					note_mismatch("wrong field", want, got, m_tdata[39:33]);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: noise while hunting, repeated first header with zero length,
		// wrong second header, over-length drop, bad checksum on corner payload
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_SECOND);
		send_byte(HDR_FIRST);
		queue_frame(8'h00, 0, 0, 0, 1'b0);
		send_byte(HDR_FIRST);
		send_byte(8'h05);
		queue_frame(8'hFF, 65, 0, 4, 1'b0);
		queue_frame(8'hA5, 2, 3, 0, 1'b1);
		wait_idle();

		write_max_length(8'hFF);
		queue_random_traffic(150);
		wait_idle();

		// only zero-length frames survive
		write_max_length(8'h00);
		queue_random_traffic(60);
		wait_idle();

		write_max_length(8'h01);
		queue_random_traffic(60);
		wait_idle();

		// receiver holds off while the sender keeps pushing
		mid_limit = 8'($urandom_range(2, 254));
		write_max_length(mid_limit);
		tx_idle = 1'b0;
		stall_req++;
		queue_random_traffic(120);
		wait_idle();

		// a stretch with no idling on either side
		write_max_length(MAX_LEN_RESET);
		rx_idle = 1'b0;
		queue_random_traffic(60);
		wait_idle();

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		queue_random_traffic(60);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("ran %0d bytes over max lengths 64, 255, 0, 1, %0d and 64,",
			bytes_taken, mid_limit);
		$display("one long receiver hold, %0d payload items checked", payload_seen);
		$display("%0d good and %0d bad frames, %0d dropped for length",
			frames_good, frames_bad, frames_dropped);
		if (mismatches == 0 && deframed_due.size() == 0) begin
			$display("PASS serial_packet_deframer");
		end else begin
			$display("%0d mismatches, %0d items never arrived", mismatches, deframed_due.size());
			$display("FAIL serial_packet_deframer");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/spd_pkg.sv
rtl/spd_core.sv
rtl/serial_packet_deframer.sv
sim/testbench.sv
